// ----- hdl/pixel_motion_search_proxy_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the pixel motion search block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PIXEL_MOTION_SEARCH_PROXY_MACROS_SVH
`define PIXEL_MOTION_SEARCH_PROXY_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, sampled on the rising clock, off while reset is low.
`define PMSP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Same-cycle implication.
`define PMSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define PMSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PMSP_ASSERT(lbl, clk, rstn, prop, msg)
`define PMSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define PMSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hdl/pmsp_pkg.sv -----
// ---------------------------------------------------------------------------
// pmsp_pkg
// Shared constants, command/status types and the offset magnitude table.
// ---------------------------------------------------------------------------
`default_nettype none

package pmsp_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int MAX_RADIUS = 7;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int RAD_W  = 3;
    localparam int OFS_W  = RAD_W + 1;          // signed offset -R..+R
    localparam int POS_W  = ROW_W + 2;          // signed probe coordinate
    localparam int LUMA_W = 8;
    localparam int MAG_W  = 12;
    localparam int ADDR_W = 1 + ROW_W + COL_W;  // bank, row, column

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int GEO_W      = 7;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - MAG_W - LUMA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 3'd1;
    localparam logic [GEO_W-1:0] WIDTH_RESET  = 7'd64;
    localparam logic [GEO_W-1:0] HEIGHT_RESET = 7'd64;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic scan_init;  // load window start and clear best match
        logic scan_step;  // read one probe and advance the window
        logic out_load;   // capture result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_hp;    // accepted pixel has a previous frame
        logic scan_last;  // current probe is the last of the window
    } t_status;

    // Q4.8 length of offset (adx, ady), rounded to nearest.
    function automatic logic [MAG_W-1:0] f_mag(input logic [RAD_W-1:0] adx,
                                               input logic [RAD_W-1:0] ady);
        logic [6:0]       sq;
        logic [MAG_W-1:0] m;
        sq = 7'(adx * adx) + 7'(ady * ady);
        case (sq)
            7'd0:    m = 12'd0;
            7'd1:    m = 12'd256;
            7'd2:    m = 12'd362;
            7'd4:    m = 12'd512;
            7'd5:    m = 12'd572;
            7'd8:    m = 12'd724;
            7'd9:    m = 12'd768;
            7'd10:   m = 12'd810;
            7'd13:   m = 12'd923;
            7'd16:   m = 12'd1024;
            7'd17:   m = 12'd1056;
            7'd18:   m = 12'd1086;
            7'd20:   m = 12'd1145;
            7'd25:   m = 12'd1280;
            7'd26:   m = 12'd1305;
            7'd29:   m = 12'd1379;
            7'd32:   m = 12'd1448;
            7'd34:   m = 12'd1493;
            7'd36:   m = 12'd1536;
            7'd37:   m = 12'd1557;
            7'd40:   m = 12'd1619;
            7'd41:   m = 12'd1639;
            7'd45:   m = 12'd1717;
            7'd49:   m = 12'd1792;
            7'd50:   m = 12'd1810;
            7'd52:   m = 12'd1846;
            7'd53:   m = 12'd1864;
            7'd58:   m = 12'd1950;
            7'd61:   m = 12'd1999;
            7'd65:   m = 12'd2064;
            7'd72:   m = 12'd2172;
            7'd74:   m = 12'd2202;
            7'd85:   m = 12'd2360;
            7'd98:   m = 12'd2534;
            default: m = 12'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pmsp_ctrl.sv -----
// ---------------------------------------------------------------------------
// pmsp_ctrl
// Sequencer: accept a pixel, sweep the search window, hand off the result.
// ---------------------------------------------------------------------------
`default_nettype none

module pmsp_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    input  pmsp_pkg::t_status i_status,
    output pmsp_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   slot_free;

    assign slot_free     = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_out_vld = r_out_vld && !m_axis_tready;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.accept    = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state = i_status.item_hp ? S_SCAN : S_RESULT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last probe compares this cycle
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pmsp_dpath.sv -----
// ---------------------------------------------------------------------------
// pmsp_dpath
// Config registers, raster counters, ping-pong frame store and match logic.
// ---------------------------------------------------------------------------
`default_nettype none

module pmsp_dpath (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire  [pmsp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire  [pmsp_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  wire  [pmsp_pkg::LUMA_W-1:0]            i_luma,
    input  wire                                    i_clip,
    input  pmsp_pkg::t_cmd                         i_cmd,
    output pmsp_pkg::t_status                      o_status,
    output logic [pmsp_pkg::OUT_TDATA_W-1:0]       o_tdata
);

    localparam int COL_W = pmsp_pkg::COL_W;
    localparam int ROW_W = pmsp_pkg::ROW_W;
    localparam int RAD_W = pmsp_pkg::RAD_W;
    localparam int OFS_W = pmsp_pkg::OFS_W;
    localparam int POS_W = pmsp_pkg::POS_W;
    localparam int LW    = pmsp_pkg::LUMA_W;
    localparam int GEO_W = pmsp_pkg::GEO_W;
    localparam int AW    = pmsp_pkg::ADDR_W;

    // Configuration
    logic [RAD_W-1:0] r_radius;
    logic [GEO_W-1:0] r_width;
    logic [GEO_W-1:0] r_height;
    logic [GEO_W-1:0] w_eff;
    logic [GEO_W-1:0] h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= pmsp_pkg::RADIUS_RESET;
            r_width  <= pmsp_pkg::WIDTH_RESET;
            r_height <= pmsp_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pmsp_pkg::CFG_SEARCH_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                pmsp_pkg::CFG_FRAME_WIDTH:   r_width  <= i_cfg_data[GEO_W-1:0];
                pmsp_pkg::CFG_FRAME_HEIGHT:  r_height <= i_cfg_data[GEO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp geometry to 1..MAX
    always_comb begin
        if (r_width == '0) begin
            w_eff = GEO_W'(1);
        end else if (r_width > GEO_W'(pmsp_pkg::MAX_WIDTH)) begin
            w_eff = GEO_W'(pmsp_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = GEO_W'(1);
        end else if (r_height > GEO_W'(pmsp_pkg::MAX_HEIGHT)) begin
            h_eff = GEO_W'(pmsp_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // Raster position and bank
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_bank;
    logic             r_hp;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             cur_hp;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;

    assign cur_col = i_clip ? '0 : r_col;
    assign cur_row = i_clip ? '0 : r_row;
    assign cur_hp  = i_clip ? 1'b0 : r_hp;
    assign col_inc = {1'b0, cur_col} + (COL_W+1)'(1);
    assign row_inc = {1'b0, cur_row} + (ROW_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= 1'b0;
            r_hp   <= 1'b0;
        end else if (i_cmd.accept) begin
            r_hp <= cur_hp;
            if (GEO_W'(col_inc) >= w_eff) begin
                r_col <= '0;
                if (GEO_W'(row_inc) >= h_eff) begin
                    r_row  <= '0;
                    r_bank <= !r_bank;
                    r_hp   <= 1'b1;
                end else begin
                    r_row <= row_inc[ROW_W-1:0];
                end
            end else begin
                r_col <= col_inc[COL_W-1:0];
                r_row <= cur_row;
            end
        end
    end

    // Per-item context
    logic [LW-1:0]    r_cur;
    logic [COL_W-1:0] r_x;
    logic [ROW_W-1:0] r_y;
    logic             r_pbank;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur   <= i_luma;
            r_x     <= cur_col;
            r_y     <= cur_row;
            r_pbank <= !r_bank;
        end
    end

    // Window sweep: dy outer, dx inner, both from -R to +R
    logic signed [OFS_W-1:0] r_dy;
    logic signed [OFS_W-1:0] r_dx;
    logic signed [OFS_W-1:0] pos_r;
    logic signed [OFS_W-1:0] neg_r;
    logic signed [POS_W-1:0] yp;
    logic signed [POS_W-1:0] xp;
    logic                    probe_in;
    logic [OFS_W-1:0]        adx_full;
    logic [OFS_W-1:0]        ady_full;

    assign pos_r = $signed({1'b0, r_radius});
    assign neg_r = -pos_r;

    assign yp = $signed({2'b00, r_y}) - {{(POS_W-OFS_W){r_dy[OFS_W-1]}}, r_dy};
    assign xp = $signed({{(POS_W-COL_W){1'b0}}, r_x})
              - {{(POS_W-OFS_W){r_dx[OFS_W-1]}}, r_dx};

    assign probe_in = !yp[POS_W-1] && !xp[POS_W-1]
                   && ($unsigned(yp) < POS_W'(h_eff))
                   && ($unsigned(xp) < POS_W'(w_eff));

    assign adx_full = r_dx[OFS_W-1] ? $unsigned(-r_dx) : $unsigned(r_dx);
    assign ady_full = r_dy[OFS_W-1] ? $unsigned(-r_dy) : $unsigned(r_dy);

    assign o_status.item_hp   = cur_hp;
    assign o_status.scan_last = (r_dx == pos_r) && (r_dy == pos_r);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_dy <= neg_r;
            r_dx <= neg_r;
        end else if (i_cmd.scan_step) begin
            if (r_dx == pos_r) begin
                r_dx <= neg_r;
                r_dy <= r_dy + OFS_W'(1);
            end else begin
                r_dx <= r_dx + OFS_W'(1);
            end
        end
    end

    // Frame store: write the current pixel, read the previous bank
    logic [LW-1:0] mem [0:(2**AW)-1];
    logic [LW-1:0] r_rd_data;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_addr = {r_bank, cur_row, cur_col};
    assign rd_addr = {r_pbank, yp[ROW_W-1:0], xp[COL_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[wr_addr] <= i_luma;
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Probe tags, aligned with the read data
    logic             r_rd_vld;
    logic [RAD_W-1:0] r_rd_adx;
    logic [RAD_W-1:0] r_rd_ady;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step && probe_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_adx <= adx_full[RAD_W-1:0];
            r_rd_ady <= ady_full[RAD_W-1:0];
        end
    end

    // Best match; a best of 256 means nothing in the window yet
    logic [LW:0]      r_best;
    logic [RAD_W-1:0] r_best_adx;
    logic [RAD_W-1:0] r_best_ady;
    logic [LW-1:0]    diff;
    logic             found;

    assign diff  = (r_cur >= r_rd_data) ? (r_cur - r_rd_data) : (r_rd_data - r_cur);
    assign found = !r_best[LW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_best <= {1'b1, {LW{1'b0}}};
        end else if (r_rd_vld && ({1'b0, diff} < r_best)) begin
            r_best     <= {1'b0, diff};
            r_best_adx <= r_rd_adx;
            r_best_ady <= r_rd_ady;
        end
    end

    // Output register: {pad, residual, magnitude}
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (found) begin
                o_tdata <= {{pmsp_pkg::OUT_PAD_W{1'b0}}, r_best[LW-1:0],
                            pmsp_pkg::f_mag(r_best_adx, r_best_ady)};
            end else begin
                o_tdata <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pixel_motion_search_proxy.sv -----
// ---------------------------------------------------------------------------
// pixel_motion_search_proxy - per-pixel full search against the previous frame
// A pixel with a previous frame sweeps the whole window, one store read per window offset;
// the next pixel is taken only after the previous result is loaded into the output register.
// Reset: synchronous active-low; counters, bank and config to defaults.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pixel_motion_search_proxy_macros.svh"

// Pixels arrive in raster order. Each one is written into the current bank
// of a two-bank frame store on its input transfer, while the other bank
// holds the previous frame. For pixels that have a previous frame the
// controller sweeps the window of offsets (dy outer, dx inner, -R..+R),
// issuing one store read per cycle; probes outside the frame are read but
// dropped. The read data is registered, so the compare follows in the cycle
// after the read and a drain state follows the last probe. The first strictly
// smaller absolute difference wins.
//
// The result is held in an output register, so the next pixel may be taken
// while a finished result still waits on m_axis_tready.
//
// The frame store has no reset; only entries written earlier are compared.

module pixel_motion_search_proxy (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write port
    input  wire                                  i_cfg_we,
    input  wire  [pmsp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [pmsp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // pixel stream in
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [pmsp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] luma
    input  wire  [0:0]                           s_axis_tuser,  // [0] clip_start
    // result stream out
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [pmsp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [11:0] motion_magnitude,
                                                                // [19:12] residual, [23:20] 0
);

    pmsp_pkg::t_cmd    cmd;
    pmsp_pkg::t_status status;

    // Sequencer: owns both handshakes
    pmsp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Store, counters and compare
    pmsp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_luma     (s_axis_tdata[pmsp_pkg::LUMA_W-1:0]),
        .i_clip     (s_axis_tuser[0]),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_tdata    (m_axis_tdata)
    );

    // Checks
    `PMSP_ASSERT(a_no_step_on_accept, i_clk, i_rst_n, !(cmd.scan_step && s_axis_tready), "input ready during window sweep")
    `PMSP_ASSERT_IMPL(a_load_slot_free, i_clk, i_rst_n, cmd.out_load, (!m_axis_tvalid || m_axis_tready), "result loaded over a pending result")
    `PMSP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready), !s_axis_tready, "second transfer before result")

endmodule

`default_nettype wire
